### hdl/packet_slot_free_list_macros.svh
// Assertion macros shared by the free list block.
// Included by the top level only; it needs a clock named clk and a reset named rst.
`ifndef PACKET_SLOT_FREE_LIST_MACROS_SVH
`define PACKET_SLOT_FREE_LIST_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PSFL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("free list assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PSFL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("free list assertion failed");

`endif

### hdl/psfl_pkg.sv
// Shared constants, codes and control types for the packet slot free list.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package psfl_pkg;

  localparam int SLOTS      = 256;
  localparam int ADDR_BITS  = 40;
  localparam int IDX_BITS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int COUNT_BITS = $clog2(SLOTS + 1);
  localparam int STRIDE_BITS = 16;
  localparam int OP_BITS    = 2;
  localparam int STATUS_BITS = 2;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [COUNT_BITS-1:0] SLOTS_CNT = COUNT_BITS'(SLOTS);
  localparam logic [IDX_BITS-1:0]   LAST_IDX  = IDX_BITS'(SLOTS - 1);

  localparam logic [OP_BITS-1:0] OP_INIT   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_GET    = 2'd1;
  localparam logic [OP_BITS-1:0] OP_RETURN = 2'd2;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_BASE   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE = 1'b1;

  localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 16'd2048;

  typedef struct packed {
    logic take;
    logic fill_step;
    logic publish;
  } psfl_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic out_free;
  } psfl_stat_t;

endpackage

`default_nettype wire

### hdl/packet_slot_free_list.sv
// Top level of the packet slot free list: controller, datapath and assertions.
// Depends on psfl_pkg, psfl_ctrl, psfl_datapath and the assertion macro header.
//
// A last-in first-out stack of packet slot addresses held in one 256-entry memory.
// Each accepted word gives exactly one result word. For get, return and unused opcodes
// the memory's registered read and the pending status hold the result until the done
// state publishes it into the output register; no new word is accepted until then.
// An init word sweeps the memory's write port once per slot in the fill state. The
// stack holds no defined contents until init or returns write it, and the block never
// reads an entry above the free count. A finished result waits in the output register
// while the next word is accepted.
`default_nettype none
`include "packet_slot_free_list_macros.svh"

module packet_slot_free_list (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [psfl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [psfl_pkg::ADDR_BITS-1:0]      cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [psfl_pkg::OP_BITS-1:0]        opcode,
  input  wire logic [psfl_pkg::ADDR_BITS-1:0]      slot_address,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [psfl_pkg::ADDR_BITS-1:0]           granted_address,
  output logic                                     granted,
  output logic [psfl_pkg::COUNT_BITS-1:0]          free_count,
  output logic [psfl_pkg::STATUS_BITS-1:0]         status
);
  import psfl_pkg::*;

  psfl_cmd_t  cmd;
  psfl_stat_t stat;

  psfl_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .opcode  (opcode),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  psfl_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .slot_address   (slot_address),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .granted_address(granted_address),
    .granted        (granted),
    .free_count     (free_count),
    .status         (status)
  );

  `PSFL_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)
  `PSFL_ASSERT_SAME(a_grant_ok, out_valid && granted, status == ST_OK && free_count < SLOTS_CNT)
  `PSFL_ASSERT_SAME(a_full_drop, out_valid && status == ST_FULL, free_count == SLOTS_CNT)
  `PSFL_ASSERT_SAME(a_empty_get, out_valid && status == ST_EMPTY, free_count == '0 && !granted)

endmodule

`default_nettype wire

### hdl/psfl_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Standalone; holds the free address stack.
`default_nettype none

module psfl_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 256
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/psfl_ctrl.sv
// Sequencing state machine of the free list: accept, fill sweep, result hand-off.
// Depends on psfl_pkg; drives the datapath through command and status structs.
`default_nettype none

module psfl_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [psfl_pkg::OP_BITS-1:0] opcode,
  output logic                              in_stall,
  input  wire psfl_pkg::psfl_stat_t         stat,
  output psfl_pkg::psfl_cmd_t               cmd
);
  import psfl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FILL = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next    = state;
    cmd.take      = 1'b0;
    cmd.fill_step = 1'b0;
    cmd.publish   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          state_next = (opcode == OP_INIT) ? S_FILL : S_DONE;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hdl/psfl_datapath.sv
// Datapath of the free list: configuration, stack pointer, fill cursor, stack memory
// and output register. Depends on psfl_pkg and psfl_ram.
`default_nettype none

module psfl_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [psfl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [psfl_pkg::ADDR_BITS-1:0]      cfg_data,
  input  wire logic [psfl_pkg::OP_BITS-1:0]        opcode,
  input  wire logic [psfl_pkg::ADDR_BITS-1:0]      slot_address,
  input  wire psfl_pkg::psfl_cmd_t                 cmd,
  output psfl_pkg::psfl_stat_t                     stat,
  input  wire logic                                out_stall,
  output logic                                     out_valid,
  output logic [psfl_pkg::ADDR_BITS-1:0]           granted_address,
  output logic                                     granted,
  output logic [psfl_pkg::COUNT_BITS-1:0]          free_count,
  output logic [psfl_pkg::STATUS_BITS-1:0]         status
);
  import psfl_pkg::*;

  logic [ADDR_BITS-1:0]   buffer_base;
  logic [STRIDE_BITS-1:0] slot_bytes;
  logic [COUNT_BITS-1:0]  count;
  logic [COUNT_BITS-1:0]  count_dec;
  logic [IDX_BITS-1:0]    fill_idx;
  logic [ADDR_BITS-1:0]   cursor;
  logic                   pend_granted;
  logic [STATUS_BITS-1:0] pend_status;
  logic                   is_empty;
  logic                   is_full;
  logic                   ram_we;
  logic [IDX_BITS-1:0]    ram_waddr;
  logic [ADDR_BITS-1:0]   ram_wdata;
  logic                   ram_re;
  logic [ADDR_BITS-1:0]   ram_rdata;

  assign is_empty  = (count == '0);
  assign is_full   = (count == SLOTS_CNT);
  assign count_dec = count - 1'b1;

  assign ram_re    = cmd.take && (opcode == OP_GET) && !is_empty;
  assign ram_we    = cmd.fill_step || (cmd.take && (opcode == OP_RETURN) && !is_full);
  assign ram_waddr = cmd.fill_step ? fill_idx : count[IDX_BITS-1:0];
  assign ram_wdata = cmd.fill_step ? cursor : slot_address;

  assign stat.fill_last = (fill_idx == LAST_IDX);
  assign stat.out_free  = !out_valid || !out_stall;

  psfl_ram #(
    .WIDTH(ADDR_BITS),
    .DEPTH(SLOTS)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(count_dec[IDX_BITS-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_base <= '0;
      slot_bytes  <= STRIDE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BASE:   buffer_base <= cfg_data;
        REG_STRIDE: slot_bytes  <= cfg_data[STRIDE_BITS-1:0];
        default:    buffer_base <= buffer_base;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.take) begin
      case (opcode)
        OP_GET: begin
          if (!is_empty) begin
            count <= count_dec;
          end
        end
        OP_RETURN: begin
          if (!is_full) begin
            count <= count + 1'b1;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end else if (cmd.fill_step && stat.fill_last) begin
      count <= SLOTS_CNT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      fill_idx     <= '0;
      cursor       <= buffer_base;
      pend_granted <= 1'b0;
      pend_status  <= ST_OK;
      case (opcode)
        OP_GET: begin
          pend_granted <= !is_empty;
          pend_status  <= is_empty ? ST_EMPTY : ST_OK;
        end
        OP_RETURN: begin
          pend_status <= is_full ? ST_FULL : ST_OK;
        end
        default: begin
          pend_status <= ST_OK;
        end
      endcase
    end else if (cmd.fill_step) begin
      fill_idx <= fill_idx + 1'b1;
      cursor   <= cursor + ADDR_BITS'(slot_bytes);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      granted_address <= pend_granted ? ram_rdata : '0;
      granted         <= pend_granted;
      free_count      <= count;
      status          <= pend_status;
    end
  end

endmodule

`default_nettype wire

### test/tb_packet_slot_free_list.sv
// Self-checking testbench for the packet_slot_free_list block: a directed table, then
// random get/return/init/unused traffic checked against an in-bench stack predictor.
// Depends on psfl_pkg and the packet_slot_free_list RTL only.
`timescale 1ns / 100ps

module tb_packet_slot_free_list;
  import psfl_pkg::*;

  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam logic [ADDR_BITS-1:0] ADDR_ONES = '1;

  typedef struct packed {
    logic [ADDR_BITS-1:0]   addr;
    logic                   grant;
    logic [COUNT_BITS-1:0]  count;
    logic [STATUS_BITS-1:0] status;
  } slot_result_t;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [ADDR_BITS-1:0] addr;
    logic                 typed;
    slot_result_t         want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [ADDR_BITS-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [OP_BITS-1:0] opcode;
  logic [ADDR_BITS-1:0] slot_address;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ADDR_BITS-1:0] granted_address;
  logic granted;
  logic [COUNT_BITS-1:0] free_count;
  logic [STATUS_BITS-1:0] status;

  logic [ADDR_BITS-1:0] slot_store [SLOTS];
  logic [COUNT_BITS-1:0] free_slots;
  logic [ADDR_BITS-1:0] cfg_base;
  logic [STRIDE_BITS-1:0] cfg_stride;
  logic [ADDR_BITS-1:0] handed_out [$];
  slot_result_t pending_results [$];

  int failures = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  directed_row_t directed_rows [0:16] = '{
    '{OP_GET,     40'h0,          1'b1, '{40'h0, 1'b0, 9'd0, ST_EMPTY}},
    '{OP_UNUSED,  ADDR_ONES,      1'b1, '{40'h0, 1'b0, 9'd0, ST_OK}},
    '{OP_RETURN,  ADDR_ONES,      1'b1, '{40'h0, 1'b0, 9'd1, ST_OK}},
    '{OP_RETURN,  40'h0,          1'b1, '{40'h0, 1'b0, 9'd2, ST_OK}},
    '{OP_GET,     ADDR_ONES,      1'b1, '{40'h0, 1'b1, 9'd1, ST_OK}},
    '{OP_GET,     40'h0,          1'b1, '{ADDR_ONES, 1'b1, 9'd0, ST_OK}},
    '{OP_GET,     40'h0,          1'b1, '{40'h0, 1'b0, 9'd0, ST_EMPTY}},
    '{OP_INIT,    40'h0,          1'b1, '{40'h0, 1'b0, 9'd256, ST_OK}},
    '{OP_RETURN,  40'hAA_AAAA_AAAA, 1'b1, '{40'h0, 1'b0, 9'd256, ST_FULL}},
    '{OP_UNUSED,  40'h55_5555_5555, 1'b1, '{40'h0, 1'b0, 9'd256, ST_OK}},
    '{OP_GET,     40'h0,          1'b0, '0},
    '{OP_GET,     40'h0,          1'b0, '0},
    '{OP_RETURN,  40'h55_5555_5555, 1'b0, '0},
    '{OP_GET,     40'h0,          1'b0, '0},
    '{OP_RETURN,  40'h80_0000_0001, 1'b0, '0},
    '{OP_INIT,    ADDR_ONES,      1'b1, '{40'h0, 1'b0, 9'd256, ST_OK}},
    '{OP_GET,     40'h0,          1'b0, '0}
  };

  packet_slot_free_list uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .slot_address(slot_address),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .granted_address(granted_address),
    .granted(granted),
    .free_count(free_count),
    .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic slot_result_t next_slot_result(input logic [OP_BITS-1:0] op,
                                                    input logic [ADDR_BITS-1:0] addr);
    slot_result_t r;
    logic [ADDR_BITS-1:0] cursor;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INIT: begin
        cursor = cfg_base;
        for (int i = 0; i < SLOTS; i++) begin
          slot_store[IDX_BITS'(i)] = cursor;
          cursor = cursor + ADDR_BITS'(cfg_stride);
        end
        free_slots = SLOTS_CNT;
      end
      OP_GET: begin
        if (free_slots != 0) begin
          free_slots = free_slots - 1'b1;
          r.addr = slot_store[free_slots[IDX_BITS-1:0]];
          r.grant = 1'b1;
          handed_out.push_back(r.addr);
          if (handed_out.size() > 512) void'(handed_out.pop_front());
        end else begin
          r.status = ST_EMPTY;
        end
      end
      OP_RETURN: begin
        if (free_slots < SLOTS_CNT) begin
          slot_store[free_slots[IDX_BITS-1:0]] = addr;
          free_slots = free_slots + 1'b1;
        end else begin
          r.status = ST_FULL;
        end
      end
      default: begin
      end
    endcase
    r.count = free_slots;
    return r;
  endfunction

  function automatic logic [ADDR_BITS-1:0] random_address();
    return {8'($urandom), 32'($urandom)};
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  // Valid stays high from one word to the next unless an idle gap is drawn.
  task automatic offer_word(input logic [OP_BITS-1:0] op, input logic [ADDR_BITS-1:0] addr,
                            input logic typed, input slot_result_t want);
    slot_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    slot_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = next_slot_result(op, addr);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_regs(input logic [ADDR_BITS-1:0] base,
                           input logic [STRIDE_BITS-1:0] stride);
    cfg_write <= 1'b1;
    cfg_index <= REG_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= REG_STRIDE;
    cfg_data <= ADDR_BITS'(stride);
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_base = base;
    cfg_stride = stride;
  endtask

  // Mostly runs of gets or returns, so the free count swings between empty and full.
  task automatic random_phase(input int words);
    int sent;
    int pick;
    int run;
    logic [OP_BITS-1:0] op;
    logic [ADDR_BITS-1:0] addr;
    sent = 0;
    offer_word(OP_INIT, random_address(), 1'b0, '0);
    while (sent < words) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        offer_word(OP_INIT, random_address(), 1'b0, '0);
        sent++;
      end else if (pick < 8) begin
        offer_word(OP_UNUSED, random_address(), 1'b0, '0);
        sent++;
      end else begin
        run = $urandom_range(1, 120);
        for (int k = 0; k < run && sent < words; k++) begin
          op = (pick < 52) ? OP_GET : OP_RETURN;
          if ($urandom_range(19) == 0) op = OP_BITS'($urandom_range(3));
          addr = random_address();
          if (op == OP_RETURN && handed_out.size() != 0 && $urandom_range(9) < 7)
            addr = handed_out.pop_back();
          offer_word(op, addr, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    slot_result_t seen;
    slot_result_t want;
    if (!rst && out_valid && !out_stall) begin
      seen = '{granted_address, granted, free_count, status};
      if (pending_results.size() == 0) begin
        note_failure($sformatf("Unexpected word: addr %h granted %b count %0d status %0d",
                               seen.addr, seen.grant, seen.count, seen.status));
      end else begin
        want = pending_results.pop_front();
        if (seen.addr !== want.addr || seen.grant !== want.grant ||
            seen.count !== want.count || seen.status !== want.status)
          note_failure($sformatf(
            "Mismatch: expected addr %h granted %b count %0d status %0d, got %h %b %0d %0d",
            want.addr, want.grant, want.count, want.status,
            seen.addr, seen.grant, seen.count, seen.status));
      end
    end
  end

  initial begin
    logic [ADDR_BITS-1:0] bases [4];
    logic [STRIDE_BITS-1:0] strides [4];
    int idle_by_phase [4];
    int stall_by_phase [4];
    idle_by_phase = '{0, 84, 0, 24};
    stall_by_phase = '{0, 0, 84, 24};
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_BASE;
    cfg_data <= '0;
    in_valid <= 1'b0;
    opcode <= OP_INIT;
    slot_address <= '0;
    cfg_base = '0;
    cfg_stride = STRIDE_RESET;
    free_slots = '0;
    bases = '{ADDR_ONES, 40'h0, random_address(), random_address()};
    strides = '{16'hFFFF, 16'h0001, 16'h0000, 16'($urandom_range(1, 65535))};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_word(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].typed,
                 directed_rows[i].want);

    for (int p = 0; p < 4; p++) begin
      drain_results();
      load_regs(bases[p], strides[p]);
      send_idle_pct = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      random_phase(330);
    end

    // The output is held off for a long stretch while words keep coming.
    drain_results();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles <= 400;
    random_phase(40);

    drain_results();
    repeat (20) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### packet_slot_free_list.f
+incdir+hdl
hdl/psfl_pkg.sv
hdl/psfl_ram.sv
hdl/psfl_ctrl.sv
hdl/psfl_datapath.sv
hdl/packet_slot_free_list.sv
test/tb_packet_slot_free_list.sv
